>>> design/pfa_pkg.sv
// Shared constants, types and helpers of the page frame allocator.
package pfa_pkg;

   // Table geometry
   localparam int FRAME_DEPTH = 64;
   localparam int PID_BITS    = 8;
   localparam int FRAME_IDX_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
   localparam int NEED_CAP    = FRAME_DEPTH + 1;
   localparam int NEED_W      = $clog2(FRAME_DEPTH + 2);

   // Transaction field widths
   localparam int MODE_W         = 2;
   localparam int OWNER_ID_W     = 8;
   localparam int REQUEST_SIZE_W = 16;
   localparam int STATUS_W       = 3;
   localparam int FRAME_INDEX_W  = 6;
   localparam int FRAME_COUNT_W  = 7;
   localparam int BYTES_W        = 23;

   // Configuration registers
   localparam int BPF_W       = 17;
   localparam int FIN_W       = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_FRAME = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMES_IN_USE   = 1'd1;
   localparam logic [BPF_W-1:0] BPF_RESET = 17'd4096;
   localparam logic [FIN_W-1:0] FIN_RESET = 7'd4;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_GRANTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RESIDENT = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RELEASED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_REPORT   = 3'd4;

   localparam int PROD_W = CNT_W + BPF_W;
   localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

   typedef struct packed {
      logic                used;
      logic [PID_BITS-1:0] owner;
   } pfa_entry_type;

   typedef struct packed {
      logic                   rd_en;
      logic [FRAME_IDX_W-1:0] rd_addr;
      logic                   wr_en;
      logic [FRAME_IDX_W-1:0] wr_addr;
      pfa_entry_type          wr_data;
   } pfa_ram_cmd_type;

   typedef struct packed {
      logic               done;
      logic [NEED_W-1:0]  count;
   } pfa_need_type;

   // Frames times frame size, saturated to the byte field
   function automatic logic [BYTES_W-1:0] sat_bytes(input logic [CNT_W-1:0] frames,
                                                   input logic [BPF_W-1:0] bpf);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(frames) * PROD_W'(bpf);
      if (prod > PROD_W'(BYTES_MAX)) begin
         return BYTES_MAX;
      end
      return BYTES_W'(prod);
   endfunction

endpackage

>>> design/pfa_req_if.sv
// Request channel interface of the page frame allocator.
interface pfa_req_if
   import pfa_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic [OWNER_ID_W-1:0]     owner_id;
   logic [REQUEST_SIZE_W-1:0] request_size;

   modport source (output valid, output mode, output owner_id, output request_size,
                   input ready);
   modport sink   (input valid, input mode, input owner_id, input request_size,
                   output ready);
endinterface

>>> design/pfa_rsp_if.sv
// Response channel interface of the page frame allocator.
interface pfa_rsp_if
   import pfa_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [FRAME_INDEX_W-1:0] frame_index;
   logic [FRAME_COUNT_W-1:0] frame_count;
   logic [BYTES_W-1:0]       used_bytes;
   logic [BYTES_W-1:0]       free_bytes;
   logic                     last;

   modport source (output valid, output status, output frame_index, output frame_count,
                   output used_bytes, output free_bytes, output last, input ready);
   modport sink   (input valid, input status, input frame_index, input frame_count,
                   input used_bytes, input free_bytes, input last, output ready);
endinterface

>>> design/pfa_frame_ram.sv
// Frame table memory: used bit and owner per frame, registered read.
module pfa_frame_ram
   import pfa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  pfa_ram_cmd_type cmd,
   output pfa_entry_type   rd_data
);

   pfa_entry_type           frame_mem [FRAME_DEPTH];
   pfa_entry_type           rd_data_ff;
   logic                    rd_vld_ff;
   logic [FRAME_DEPTH-1:0]  vld_ff;

   // Entries never written since reset read as free
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.wr_en) begin
         vld_ff[cmd.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         frame_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= frame_mem[cmd.rd_addr];
         rd_vld_ff  <= vld_ff[cmd.rd_addr];
      end
   end

   assign rd_data.used  = rd_vld_ff & rd_data_ff.used;
   assign rd_data.owner = rd_data_ff.owner;

endmodule

>>> design/pfa_need_calc.sv
// Frame demand counter: ceiling of size over frame size, capped at FRAME_DEPTH + 1, one frame per cycle.
module pfa_need_calc
   import pfa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [REQUEST_SIZE_W-1:0] size,
   input  logic [BPF_W-1:0]          bpf,
   output pfa_need_type              need
);

   localparam int ACC_W = REQUEST_SIZE_W + 2;

   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [NEED_W-1:0]         cnt_ff, cnt_in;
   logic [REQUEST_SIZE_W-1:0] size_ff, size_in;
   logic [BPF_W-1:0]          bpf_eff;
   logic                      done;

   // A zero frame size divides as one
   assign bpf_eff = (bpf == '0) ? BPF_W'(1) : bpf;
   assign done    = (acc_ff >= ACC_W'(size_ff)) || (cnt_ff == NEED_W'(NEED_CAP));

   always_comb begin
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      size_in = size_ff;
      if (start) begin
         acc_in  = '0;
         cnt_in  = '0;
         size_in = size;
      end else if (!done) begin
         acc_in = acc_ff + ACC_W'(bpf_eff);
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         cnt_ff  <= '0;
         size_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         size_ff <= size_in;
      end
   end

   assign need.done  = done;
   assign need.count = cnt_ff;

endmodule

>>> design/pfa_ctrl.sv
// Sequencer: table scans, decision, frame grants and the response register.
module pfa_ctrl
   import pfa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   pfa_req_if.sink                   req,
   pfa_rsp_if.source                 rsp,
   input  logic [BPF_W-1:0]          bpf,
   input  logic [CNT_W-1:0]          lim,
   output pfa_ram_cmd_type           ram_cmd,
   input  pfa_entry_type             ram_rd,
   output logic                      need_start,
   output logic [REQUEST_SIZE_W-1:0] need_size,
   input  pfa_need_type              need
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_REPLY  = 3'd3;
   localparam logic [2:0] ST_GRANT  = 3'd4;

   localparam logic [FRAME_IDX_W-1:0] LAST_IDX = FRAME_IDX_W'(FRAME_DEPTH - 1);

   logic [2:0]             state_ff, state_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [PID_BITS-1:0]    pid_ff, pid_in;
   logic [CNT_W-1:0]       addr_ff, addr_in;
   logic                   pend_ff, pend_in;
   logic [FRAME_IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic                   resident_ff, resident_in;
   logic [CNT_W-1:0]       free_ff, free_in;
   logic [CNT_W-1:0]       freed_ff, freed_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic [NEED_W-1:0]      need_ff, need_in;
   logic [NEED_W-1:0]      grant_cnt_ff, grant_cnt_in;
   logic [CNT_W-1:0]       final_cnt_ff, final_cnt_in;
   logic [STATUS_W-1:0]    reply_status_ff, reply_status_in;
   logic [CNT_W-1:0]       reply_count_ff, reply_count_in;

   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [FRAME_INDEX_W-1:0] rsp_index_ff;
   logic [FRAME_COUNT_W-1:0] rsp_count_ff;
   logic [BYTES_W-1:0]       rsp_used_ff;
   logic [BYTES_W-1:0]       rsp_free_ff;
   logic                     rsp_last_ff;

   logic                     out_load;
   logic [STATUS_W-1:0]      out_status;
   logic [FRAME_INDEX_W-1:0] out_index;
   logic [CNT_W-1:0]         out_count;
   logic [CNT_W-1:0]         out_used_frames;
   logic [CNT_W-1:0]         out_free_frames;
   logic                     out_last;

   logic slot_free;
   logic own_match;
   logic in_lim;
   logic release_hit;
   logic grant_hit;
   logic stall;
   logic grant_last;

   assign slot_free   = !rsp_valid_ff || rsp.ready;
   assign own_match   = ram_rd.used && (ram_rd.owner == pid_ff);
   assign in_lim      = CNT_W'(pend_idx_ff) < lim;
   assign release_hit = (mode_ff == MODE_RELEASE) && own_match;
   assign grant_hit   = pend_ff && !ram_rd.used;
   assign stall       = grant_hit && !slot_free;
   assign grant_last  = NEED_W'(grant_cnt_ff + 1'b1) == need_ff;

   assign req.ready  = (state_ff == ST_IDLE);
   assign need_start = req.valid && (state_ff == ST_IDLE);
   assign need_size  = req.request_size;

   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      pid_in          = pid_ff;
      addr_in         = addr_ff;
      pend_in         = pend_ff;
      pend_idx_in     = pend_idx_ff;
      resident_in     = resident_ff;
      free_in         = free_ff;
      freed_in        = freed_ff;
      total_in        = total_ff;
      need_in         = need_ff;
      grant_cnt_in    = grant_cnt_ff;
      final_cnt_in    = final_cnt_ff;
      reply_status_in = reply_status_ff;
      reply_count_in  = reply_count_ff;
      ram_cmd         = '0;
      out_load        = 1'b0;
      out_status      = STATUS_REPORT;
      out_index       = '0;
      out_count       = '0;
      out_used_frames = total_ff;
      out_free_frames = free_ff;
      out_last        = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               mode_in     = req.mode;
               pid_in      = PID_BITS'(req.owner_id);
               addr_in     = '0;
               pend_in     = 1'b0;
               resident_in = 1'b0;
               free_in     = '0;
               freed_in    = '0;
               state_in    = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Stream every entry: residency, free count, release write-back
            if (addr_ff < CNT_W'(FRAME_DEPTH)) begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = addr_ff[FRAME_IDX_W-1:0];
               pend_idx_in     = addr_ff[FRAME_IDX_W-1:0];
               addr_in         = addr_ff + 1'b1;
               pend_in         = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (own_match) begin
                  resident_in = 1'b1;
               end
               if (release_hit) begin
                  ram_cmd.wr_en         = 1'b1;
                  ram_cmd.wr_addr       = pend_idx_ff;
                  ram_cmd.wr_data.used  = 1'b0;
                  ram_cmd.wr_data.owner = pid_ff;
                  freed_in              = freed_ff + 1'b1;
                  if (total_ff != '0) begin
                     total_in = total_ff - 1'b1;
                  end
               end
               if (in_lim && (!ram_rd.used || release_hit)) begin
                  free_in = free_ff + 1'b1;
               end
               if (pend_idx_ff == LAST_IDX) begin
                  state_in = ST_DECIDE;
               end
            end
         end

         ST_DECIDE: begin
            if (need.done) begin
               state_in       = ST_REPLY;
               reply_count_in = free_ff;
               case (mode_ff)
                  MODE_ALLOC: begin
                     if (resident_ff) begin
                        reply_status_in = STATUS_RESIDENT;
                     end else if (need.count == '0) begin
                        reply_status_in = STATUS_REPORT;
                     end else if (need.count > NEED_W'(free_ff)) begin
                        reply_status_in = STATUS_SHORT;
                     end else begin
                        need_in      = need.count;
                        grant_cnt_in = '0;
                        final_cnt_in = free_ff - CNT_W'(need.count);
                        addr_in      = '0;
                        pend_in      = 1'b0;
                        state_in     = ST_GRANT;
                     end
                  end
                  MODE_RELEASE: begin
                     reply_status_in = STATUS_RELEASED;
                     reply_count_in  = freed_ff;
                  end
                  default: begin
                     reply_status_in = STATUS_REPORT;
                  end
               endcase
            end
         end

         ST_REPLY: begin
            if (slot_free) begin
               out_load   = 1'b1;
               out_status = reply_status_ff;
               out_count  = reply_count_ff;
               state_in   = ST_IDLE;
            end
         end

         ST_GRANT: begin
            // Re-read the held entry while the response slot is full
            if (stall) begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = pend_idx_ff;
            end else if (addr_ff < CNT_W'(FRAME_DEPTH)) begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = addr_ff[FRAME_IDX_W-1:0];
               pend_idx_in     = addr_ff[FRAME_IDX_W-1:0];
               addr_in         = addr_ff + 1'b1;
               pend_in         = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (grant_hit && !stall) begin
               ram_cmd.wr_en         = 1'b1;
               ram_cmd.wr_addr       = pend_idx_ff;
               ram_cmd.wr_data.used  = 1'b1;
               ram_cmd.wr_data.owner = pid_ff;
               total_in              = total_ff + 1'b1;
               free_in               = free_ff - 1'b1;
               grant_cnt_in          = grant_cnt_ff + 1'b1;
               out_load              = 1'b1;
               out_status            = STATUS_GRANTED;
               out_index             = FRAME_INDEX_W'(pend_idx_ff);
               out_count             = final_cnt_ff;
               out_used_frames       = total_ff + 1'b1;
               out_free_frames       = free_ff - 1'b1;
               out_last              = grant_last;
               if (grant_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         total_ff <= total_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff         <= mode_in;
      pid_ff          <= pid_in;
      addr_ff         <= addr_in;
      pend_idx_ff     <= pend_idx_in;
      resident_ff     <= resident_in;
      free_ff         <= free_in;
      freed_ff        <= freed_in;
      need_ff         <= need_in;
      grant_cnt_ff    <= grant_cnt_in;
      final_cnt_ff    <= final_cnt_in;
      reply_status_ff <= reply_status_in;
      reply_count_ff  <= reply_count_in;
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_index_ff  <= out_index;
         rsp_count_ff  <= FRAME_COUNT_W'(out_count);
         rsp_used_ff   <= sat_bytes(out_used_frames, bpf);
         rsp_free_ff   <= sat_bytes(out_free_frames, bpf);
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.frame_index = rsp_index_ff;
   assign rsp.frame_count = rsp_count_ff;
   assign rsp.used_bytes  = rsp_used_ff;
   assign rsp.free_bytes  = rsp_free_ff;
   assign rsp.last        = rsp_last_ff;

endmodule

>>> design/page_frame_allocator_top.sv
// Page frame allocator top level: configuration registers and block wiring.
//
// Request channel req_ch carries one transaction per command: allocate,
// release or usage query, with a process id and a byte size. Response
// channel rsp_ch returns one transaction per granted frame (allocate), or a
// single status transaction otherwise; the final one carries last.
// Configuration: csr_we writes csr_wdata to register csr_index (0 frame size
// in bytes, 1 number of available frames) at the clock edge.
//
// Sequence: a command is taken only while the block is idle. It first streams
// the whole frame table through the memory read port, then decides and loads
// the response register; the next command is taken once a status response is
// loaded. A successful allocate streams the table again from frame 0: one
// grant per free frame met until the demand is covered. The single table port
// sets this rate. Synchronous reset marks every frame free, clears the
// used-frame total and restores the default configuration. A stalled receiver
// holds the response register; the grant scan holds on the current frame.
module page_frame_allocator_top
   import pfa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   pfa_req_if.sink                req_ch,
   pfa_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [BPF_W-1:0]          bpf_ff;
   logic [FIN_W-1:0]          fin_ff;
   logic [CNT_W-1:0]          lim;
   pfa_ram_cmd_type           ram_cmd;
   pfa_entry_type             ram_rd;
   logic                      need_start;
   logic [REQUEST_SIZE_W-1:0] need_size;
   pfa_need_type              need;

   // Register writes land directly, no handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         bpf_ff <= BPF_RESET;
         fin_ff <= FIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BYTES_PER_FRAME: bpf_ff <= BPF_W'(csr_wdata);
            CSR_FRAMES_IN_USE:   fin_ff <= FIN_W'(csr_wdata);
            default: begin
               bpf_ff <= bpf_ff;
            end
         endcase
      end
   end

   // Clamp the available frame count to the table depth
   always_comb begin
      if (32'(fin_ff) > 32'(FRAME_DEPTH)) begin
         lim = CNT_W'(FRAME_DEPTH);
      end else begin
         lim = CNT_W'(fin_ff);
      end
   end

   pfa_frame_ram u_frame_ram (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ram_cmd),
      .rd_data (ram_rd)
   );

   pfa_need_calc u_need_calc (
      .clock (clock),
      .reset (reset),
      .start (need_start),
      .size  (need_size),
      .bpf   (bpf_ff),
      .need  (need)
   );

   pfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .bpf        (bpf_ff),
      .lim        (lim),
      .ram_cmd    (ram_cmd),
      .ram_rd     (ram_rd),
      .need_start (need_start),
      .need_size  (need_size),
      .need       (need)
   );

endmodule

>>> dv/frame_table_checker.sv
// Frame table checker: predicts allocator responses from observed traffic and compares them.
module frame_table_checker
   import pfa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   pfa_req_if                     req_mon,
   pfa_rsp_if                     rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            outstanding,
   output int unsigned            fail_count
);

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [FRAME_INDEX_W-1:0] frame_index;
      logic [FRAME_COUNT_W-1:0] frame_count;
      logic [BYTES_W-1:0]       used_bytes;
      logic [BYTES_W-1:0]       free_bytes;
      logic                     last;
   } frame_rsp_type;

   frame_rsp_type          expected_rsp [$];
   logic [FRAME_DEPTH-1:0] frame_busy;
   logic [PID_BITS-1:0]    frame_pid [FRAME_DEPTH];
   int unsigned            busy_total;
   logic [BPF_W-1:0]       frame_bytes;
   logic [FIN_W-1:0]       frame_cap;
   int unsigned            errors = 0;

   function automatic int unsigned table_limit();
      return (frame_cap > FRAME_DEPTH) ? FRAME_DEPTH : int'(frame_cap);
   endfunction

   // Free frames below the current limit only
   function automatic int unsigned free_frames();
      int unsigned n;
      n = 0;
      for (int i = 0; i < table_limit(); i++) begin
         if (!frame_busy[i]) n++;
      end
      return n;
   endfunction

   function automatic logic [BYTES_W-1:0] frames_to_bytes(input int unsigned frames);
      longint unsigned prod;
      prod = longint'(frames) * longint'(frame_bytes);
      if (prod > longint'(BYTES_MAX)) return BYTES_MAX;
      return BYTES_W'(prod);
   endfunction

   function automatic frame_rsp_type make_rsp(input logic [STATUS_W-1:0] status,
                                              input int unsigned idx, input int unsigned count,
                                              input bit last);
      frame_rsp_type r;
      r.status      = status;
      r.frame_index = FRAME_INDEX_W'(idx);
      r.frame_count = FRAME_COUNT_W'(count);
      r.used_bytes  = frames_to_bytes(busy_total);
      r.free_bytes  = frames_to_bytes(free_frames());
      r.last        = last;
      return r;
   endfunction

   // Append one expected transaction
   task automatic expect_rsp(input frame_rsp_type r);
      expected_rsp = {expected_rsp, r};
   endtask

   task automatic predict_command(input logic [MODE_W-1:0] mode,
                                  input logic [OWNER_ID_W-1:0] pid,
                                  input logic [REQUEST_SIZE_W-1:0] size);
      int unsigned   unit, need, freed, avail;
      bit            resident;
      frame_rsp_type grants [$];
      if (mode == MODE_ALLOC) begin
         unit = (frame_bytes == 0) ? 1 : int'(frame_bytes);
         need = (size + unit - 1) / unit;
         resident = 1'b0;
         for (int i = 0; i < FRAME_DEPTH; i++) begin
            if (frame_busy[i] && frame_pid[i] == PID_BITS'(pid)) resident = 1'b1;
         end
         if (resident) begin
            expect_rsp(make_rsp(STATUS_RESIDENT, 0, free_frames(), 1'b1));
         end else if (need == 0) begin
            expect_rsp(make_rsp(STATUS_REPORT, 0, free_frames(), 1'b1));
         end else if (free_frames() < need) begin
            expect_rsp(make_rsp(STATUS_SHORT, 0, free_frames(), 1'b1));
         end else begin
            // grant lowest free frames; byte counts follow each grant
            for (int i = 0; i < table_limit() && need > 0; i++) begin
               if (!frame_busy[i]) begin
                  frame_busy[i] = 1'b1;
                  frame_pid[i]  = PID_BITS'(pid);
                  busy_total++;
                  need--;
                  grants = {grants, make_rsp(STATUS_GRANTED, i, 0, need == 0)};
               end
            end
            avail = free_frames();
            foreach (grants[k]) begin
               grants[k].frame_count = FRAME_COUNT_W'(avail);
               expect_rsp(grants[k]);
            end
         end
      end else if (mode == MODE_RELEASE) begin
         freed = 0;
         for (int i = 0; i < FRAME_DEPTH; i++) begin
            if (frame_busy[i] && frame_pid[i] == PID_BITS'(pid)) begin
               frame_busy[i] = 1'b0;
               freed++;
               if (busy_total > 0) busy_total--;
            end
         end
         expect_rsp(make_rsp(STATUS_RELEASED, 0, freed, 1'b1));
      end else begin
         expect_rsp(make_rsp(STATUS_REPORT, 0, free_frames(), 1'b1));
      end
   endtask

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      errors++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      frame_rsp_type want;
      if (reset) begin
         expected_rsp.delete();
         frame_busy  = '0;
         busy_total  = 0;
         frame_bytes = BPF_RESET;
         frame_cap   = FIN_RESET;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected response status", rsp_mon.status, 0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_mon.status != want.status)
                  report_mismatch("status", rsp_mon.status, want.status);
               if (rsp_mon.frame_index != want.frame_index)
                  report_mismatch("frame_index", rsp_mon.frame_index, want.frame_index);
               if (rsp_mon.frame_count != want.frame_count)
                  report_mismatch("frame_count", rsp_mon.frame_count, want.frame_count);
               if (rsp_mon.used_bytes != want.used_bytes)
                  report_mismatch("used_bytes", rsp_mon.used_bytes, want.used_bytes);
               if (rsp_mon.free_bytes != want.free_bytes)
                  report_mismatch("free_bytes", rsp_mon.free_bytes, want.free_bytes);
               if (rsp_mon.last != want.last)
                  report_mismatch("last", rsp_mon.last, want.last);
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_BYTES_PER_FRAME) frame_bytes = csr_wdata[BPF_W-1:0];
            else if (csr_index == CSR_FRAMES_IN_USE) frame_cap = csr_wdata[FIN_W-1:0];
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_command(req_mon.mode, req_mon.owner_id, req_mon.request_size);
         end
      end
      outstanding <= expected_rsp.size();
      fail_count  <= errors;
   end

endmodule

>>> dv/tb_top.sv
// Testbench top for the page frame allocator: stimulus, receiver stalls and the verdict.
module tb_top;
   import pfa_pkg::*;

   // Mode value left unused by the block; it must behave as a query
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned HOLD_CYCLES = 600;
   localparam int          PHASES      = 9;
   localparam int          PHASE_ITEMS = 45;
   localparam int          HOLD_PHASE  = 6;
   localparam int          GAPLESS_PHASE = 1;

   typedef enum int unsigned {SINK_OPEN, SINK_COIN, SINK_RARE, SINK_PERIODIC} sink_style_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int unsigned            outstanding;
   int unsigned            fail_count;
   int unsigned            cycle_count = 0;
   int unsigned            hold_ticket = 0;

   // Frame size and frame count per random phase: extremes plus a few odd values
   int unsigned phase_bpf [PHASES] = '{4096, 1, 65536, 131071, 0, 512, 1024, 300, 2048};
   int unsigned phase_fin [PHASES] = '{4, 64, 64, 127, 16, 1, 100, 40, 20};

   pfa_req_if req_ch ();
   pfa_rsp_if rsp_ch ();

   page_frame_allocator_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_table_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: end the run if the block hangs or responses go missing
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: switch stall style periodically; a new hold ticket from the
   // stimulus side closes the response channel for a hold period, so the
   // block backs up into its request channel.
   initial begin : receiver
      int unsigned hold_left, hold_seen, tick;
      sink_style_type style;
      hold_left = 0;
      hold_seen = 0;
      tick      = 0;
      style     = SINK_OPEN;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (tick % 256 == 0) style = sink_style_type'($urandom_range(0, 3));
         if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (style)
               SINK_OPEN:     rsp_ch.ready <= 1'b1;
               SINK_COIN:     rsp_ch.ready <= ($urandom_range(0, 1) == 0);
               SINK_RARE:     rsp_ch.ready <= ($urandom_range(0, 7) != 0);
               default:       rsp_ch.ready <= ((tick % 7) >= 3);
            endcase
         end
      end
   end

   // Offer one transaction and hold it until the block takes it
   task automatic send_req(input logic [MODE_W-1:0] mode, input logic [OWNER_ID_W-1:0] pid,
                           input logic [REQUEST_SIZE_W-1:0] size);
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= mode;
      req_ch.owner_id     <= pid;
      req_ch.request_size <= size;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid and wait until every predicted response has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Single register write; always leaves one cycle with the enable low
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Random traffic for one configuration. Most commands are allocate and
   // release from a small pool of process ids so that frames get held, reused
   // and freed; the rest are queries, spare-mode commands and fully random noise.
   task automatic run_phase(input int unsigned items, input int unsigned unit,
                            input bit gapless);
      int unsigned                burst_left, gap, pick, need, sel;
      longint unsigned            bytes;
      logic [MODE_W-1:0]          mode;
      logic [OWNER_ID_W-1:0]      pid;
      logic [REQUEST_SIZE_W-1:0]  size;
      burst_left = 0;
      for (int n = 0; n < items; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         // now and then pause until the block has answered everything
         if ($urandom_range(0, 39) == 0) wait_drained();

         pid  = ($urandom_range(0, 4) != 0) ? OWNER_ID_W'($urandom_range(0, 7))
                                            : OWNER_ID_W'($urandom());
         size = REQUEST_SIZE_W'($urandom());
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            mode = MODE_ALLOC;
            sel  = $urandom_range(0, 19);
            if (sel == 0) begin
               size = '0;
            end else if (sel > 1) begin
               // size a whole number of frames minus a random remainder
               need  = (sel < 4) ? $urandom_range(9, 64) : $urandom_range(1, 8);
               bytes = longint'(need - 1) * unit + $urandom_range(1, unit);
               size  = (bytes > 65535) ? REQUEST_SIZE_W'($urandom_range(0, 65535))
                                       : REQUEST_SIZE_W'(bytes);
            end
         end else if (pick < 75) begin
            mode = MODE_RELEASE;
         end else if (pick < 85) begin
            mode = MODE_QUERY;
         end else if (pick < 90) begin
            mode = MODE_SPARE;
         end else begin
            mode = MODE_W'($urandom_range(0, 3));
            pid  = OWNER_ID_W'($urandom());
         end
         send_req(mode, pid, size);
         burst_left--;
      end
   endtask

   initial begin : stimulus
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.mode         <= MODE_QUERY;
      req_ch.owner_id     <= '0;
      req_ch.request_size <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset configuration: 4 frames of 4096 bytes
      send_req(MODE_QUERY, 8'd0, 16'd0);
      send_req(MODE_SPARE, 8'd255, 16'd65535);     // spare mode answers as a query
      send_req(MODE_ALLOC, 8'd1, 16'd0);           // zero size: usage report only
      send_req(MODE_ALLOC, 8'd1, 16'd1);           // one frame, frame 0
      send_req(MODE_ALLOC, 8'd1, 16'd100);         // already resident
      send_req(MODE_ALLOC, 8'd2, 16'd8193);        // rounds up to three frames
      send_req(MODE_ALLOC, 8'd3, 16'd1);           // table full: insufficient
      send_req(MODE_RELEASE, 8'd9, 16'd0);         // release of nothing
      send_req(MODE_RELEASE, 8'd1, 16'd0);
      send_req(MODE_ALLOC, 8'd255, 16'd4096);      // exact fit, reuses frame 0
      send_req(MODE_RELEASE, 8'd2, 16'd0);
      send_req(MODE_RELEASE, 8'd255, 16'd0);

      // No frames at all
      wait_drained();
      write_reg(CSR_FRAMES_IN_USE, 0);
      send_req(MODE_ALLOC, 8'd4, 16'd1);
      send_req(MODE_QUERY, 8'd4, 16'd0);

      // Frame count above the table: acts as the full table; take all of it
      wait_drained();
      write_reg(CSR_BYTES_PER_FRAME, 1024);
      write_reg(CSR_FRAMES_IN_USE, 127);
      send_req(MODE_ALLOC, 8'd5, 16'd65535);
      send_req(MODE_QUERY, 8'd5, 16'd0);
      send_req(MODE_RELEASE, 8'd5, 16'd0);

      // Zero frame size: divides as one byte, counts as zero bytes
      wait_drained();
      write_reg(CSR_BYTES_PER_FRAME, 0);
      write_reg(CSR_FRAMES_IN_USE, 64);
      send_req(MODE_ALLOC, 8'd6, 16'd3);
      send_req(MODE_ALLOC, 8'd7, 16'd65535);
      send_req(MODE_RELEASE, 8'd6, 16'd0);

      // Frames left used above a lowered limit
      wait_drained();
      write_reg(CSR_BYTES_PER_FRAME, 4096);
      send_req(MODE_ALLOC, 8'd7, 16'd40960);
      wait_drained();
      write_reg(CSR_FRAMES_IN_USE, 4);
      send_req(MODE_QUERY, 8'd0, 16'd0);
      send_req(MODE_ALLOC, 8'd8, 16'd1);
      send_req(MODE_RELEASE, 8'd7, 16'd0);

      // Frame size of 65536 bytes with a single frame
      wait_drained();
      write_reg(CSR_BYTES_PER_FRAME, 65536);
      write_reg(CSR_FRAMES_IN_USE, 1);
      send_req(MODE_ALLOC, 8'd10, 16'd65535);

      // Random phases; reconfigure only with the block drained
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         write_reg(CSR_BYTES_PER_FRAME, phase_bpf[p]);
         write_reg(CSR_FRAMES_IN_USE, phase_fin[p]);
         // hold the receiver closed while the sender keeps offering
         if (p == HOLD_PHASE) hold_ticket <= hold_ticket + 1;
         run_phase(PHASE_ITEMS, (phase_bpf[p] == 0) ? 1 : phase_bpf[p],
                   p == GAPLESS_PHASE || p == HOLD_PHASE);
      end

      // Drain, then give the block time to show any stray response
      wait_drained();
      repeat (3 * FRAME_DEPTH) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
